@@ rtl/ikl_pkg.sv @@
// Shared types and constants of the INI section/key lookup block.
// No dependencies; imported by every module of the block but ikl_checker.
package ikl_pkg;

    // Name and value limits
    localparam int NAME_MAX   = 16;
    localparam int VALUE_MAX  = 32;
    localparam int NAME_BYTES = 16;
    localparam int NAME_IDX_W = $clog2(NAME_BYTES);
    localparam int POS_W      = $clog2(NAME_MAX + 2);
    localparam int LEN_W      = 5;
    localparam int VCNT_W     = $clog2(VALUE_MAX + 1);
    localparam int ADDR_W     = $clog2(2 * VALUE_MAX);
    localparam int FIFO_DEPTH = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SECTION_LEN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LEN      = 3'd5;

    // Characters of the INI syntax
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    // Answer command from the parser to the output sequencer
    typedef struct packed {
        logic              found;
        logic              bank;
        logic [VCNT_W-1:0] count;
    } cmd_t;

    // Value buffer write request
    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        data;
    } wr_t;

    // Buffer bank released by the output sequencer
    typedef struct packed {
        logic en;
        logic bank;
    } rel_t;

    // Buffer address of an entry in one of the two banks
    function automatic logic [ADDR_W-1:0] buf_addr(input logic bank,
                                                   input logic [VCNT_W-1:0] idx);
        logic [ADDR_W-1:0] base;
        base = bank ? ADDR_W'(VALUE_MAX) : '0;
        return base + ADDR_W'(idx);
    endfunction

endpackage

@@ rtl/ini_section_key_lookup.sv @@
// INI lookup of one key in one section, top level.
// Depends on ikl_pkg, ikl_front, ikl_cmd_fifo and ikl_back.
//
// The block takes one text byte per cycle on the s_ channel while s_ready is
// high and answers each text once on the m_ channel: the found value as one
// result per byte followed by a closing result with last_of_answer set, or a
// single not-found result at end of text. Input acceptance is limited only by
// the two-entry answer queue and by the two value buffer banks: while both
// banks hold answers not yet read out, s_ready drops until the output side
// drains one. Results leave at one per cycle while m_ready is high, through
// the buffer's single read port; an answer of n bytes gives n + 1 results.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must write them only while the block is idle; the block does not enforce it.
module ini_section_key_lookup (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ikl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ikl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_text_byte,
    input  logic                            s_end_of_text,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [7:0]                      m_value_byte,
    output logic                            m_byte_valid,
    output logic                            m_key_found,
    output logic                            m_last_of_answer
);
    import ikl_pkg::*;

    logic fifo_full;
    logic fifo_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t head_cmd;
    wr_t  wr;
    rel_t release_bank;

    // Parse and classify bytes
    ikl_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_text_byte  (s_text_byte),
        .s_end_of_text(s_end_of_text),
        .fifo_full    (fifo_full),
        .release_bank (release_bank),
        .push         (push),
        .push_cmd     (push_cmd),
        .wr           (wr)
    );

    // Queue answers between the two sides
    ikl_cmd_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_cmd(push_cmd),
        .pop     (pop),
        .head    (head_cmd),
        .empty   (fifo_empty),
        .full    (fifo_full)
    );

    // Read out answers
    ikl_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .wr              (wr),
        .cmd_valid       (!fifo_empty),
        .cmd             (head_cmd),
        .pop             (pop),
        .release_bank    (release_bank),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value_byte    (m_value_byte),
        .m_byte_valid    (m_byte_valid),
        .m_key_found     (m_key_found),
        .m_last_of_answer(m_last_of_answer)
    );

endmodule

@@ rtl/ikl_cmd_fifo.sv @@
// Two-entry answer command queue between parser and output sequencer.
// Depends on ikl_pkg for cmd_t and FIFO_DEPTH.
module ikl_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  ikl_pkg::cmd_t push_cmd,
    input  logic          pop,
    output ikl_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);
    import ikl_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

    cmd_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head  = slot_reg[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(FIFO_DEPTH));

    // Advance pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

@@ rtl/ikl_front.sv @@
// Byte parser: configuration registers, line classification, name matching
// and value capture. Depends on ikl_pkg; feeds ikl_cmd_fifo and ikl_back.
module ikl_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ikl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ikl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_text_byte,
    input  logic                            s_end_of_text,
    input  logic                            fifo_full,
    input  ikl_pkg::rel_t                   release_bank,
    output logic                            push,
    output ikl_pkg::cmd_t                   push_cmd,
    output ikl_pkg::wr_t                    wr
);
    import ikl_pkg::*;

    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_SKIP       = 3'd1;
    localparam logic [2:0] PH_HDR_LEAD   = 3'd2;
    localparam logic [2:0] PH_HDR_NAME   = 3'd3;
    localparam logic [2:0] PH_KEY_NAME   = 3'd4;
    localparam logic [2:0] PH_VAL_LEAD   = 3'd5;
    localparam logic [2:0] PH_VAL_BODY   = 3'd6;
    localparam logic [2:0] PH_VAL_DONE   = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             match;
        logic             match_ln;
        logic [POS_W-1:0] len_ln;
    } name_state_t;

    localparam name_state_t NAME_BEGIN = '{pos: '0, match: 1'b1, match_ln: 1'b1, len_ln: '0};

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB};
    endfunction

    function automatic logic is_line_end(input logic [7:0] c);
        return c inside {CH_CR, CH_LF};
    endfunction

    // One name byte against the configured name
    function automatic name_state_t name_feed(input name_state_t st, input logic [7:0] c,
                                              input logic [NAME_BYTES-1:0][7:0] want);
        name_state_t ns;
        ns = st;
        if (st.pos < POS_W'(NAME_MAX)) begin
            if (to_lower(c) != to_lower(want[st.pos[NAME_IDX_W-1:0]])) begin
                ns.match = 1'b0;
            end
        end else begin
            ns.match = 1'b0;
        end
        if (st.pos <= POS_W'(NAME_MAX)) begin
            ns.pos = st.pos + 1'b1;
        end
        if (!is_blank(c)) begin
            ns.match_ln = ns.match;
            ns.len_ln   = ns.pos;
        end
        return ns;
    endfunction

    function automatic logic name_matches(input name_state_t st, input logic [LEN_W-1:0] len);
        return st.match_ln && (len <= LEN_W'(NAME_MAX)) &&
               ((POS_W + LEN_W)'(st.len_ln) == (POS_W + LEN_W)'(len));
    endfunction

    // Configuration registers
    logic [NAME_BYTES-1:0][7:0] section_name_reg;
    logic [LEN_W-1:0]           section_length_reg;
    logic [NAME_BYTES-1:0][7:0] key_name_reg;
    logic [LEN_W-1:0]           key_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            section_name_reg   <= '0;
            section_length_reg <= '0;
            key_name_reg       <= '0;
            key_length_reg     <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_SECTION_LOW:  section_name_reg[7:0]  <= cfg_data;
                REG_SECTION_HIGH: section_name_reg[15:8] <= cfg_data;
                REG_SECTION_LEN:  section_length_reg     <= cfg_data[LEN_W-1:0];
                REG_KEY_LOW:      key_name_reg[7:0]      <= cfg_data;
                REG_KEY_HIGH:     key_name_reg[15:8]     <= cfg_data;
                REG_KEY_LEN:      key_length_reg         <= cfg_data[LEN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Parser state
    logic [2:0]        phase_reg, phase_next;
    logic              in_sec_reg, in_sec_next;
    name_state_t       name_reg, name_next;
    logic [VCNT_W-1:0] vcount_reg, vcount_next;
    logic [VCNT_W-1:0] vtrim_reg, vtrim_next;
    logic              answered_reg, answered_next;
    logic              bank_reg, bank_next;
    logic [1:0]        busy_reg, busy_next;

    logic       accept;
    logic [7:0] c;

    // Stall while the queue is full or the bank to fill still holds an answer not yet read out
    assign s_ready = !fifo_full && !busy_reg[bank_reg];
    assign accept  = s_valid && s_ready;
    assign c       = s_text_byte;

    always_comb begin
        phase_next    = phase_reg;
        in_sec_next   = in_sec_reg;
        name_next     = name_reg;
        vcount_next   = vcount_reg;
        vtrim_next    = vtrim_reg;
        answered_next = answered_reg;
        bank_next     = bank_reg;
        busy_next     = busy_reg;
        push          = 1'b0;
        push_cmd      = '{found: 1'b1, bank: bank_reg, count: vtrim_reg};
        wr.en         = 1'b0;
        wr.addr       = buf_addr(bank_reg, vcount_reg);
        wr.data       = c;

        // Free a bank once its answer is read out
        if (release_bank.en) begin
            busy_next[release_bank.bank] = 1'b0;
        end

        if (accept && s_end_of_text) begin
            // Answer if still open, then restart the text state
            if (!answered_reg) begin
                push = 1'b1;
                if (phase_reg >= PH_VAL_LEAD) begin
                    busy_next[bank_reg] = 1'b1;
                    bank_next           = !bank_reg;
                end else begin
                    push_cmd = '{found: 1'b0, bank: bank_reg, count: '0};
                end
            end
            phase_next    = PH_LINE_START;
            in_sec_next   = 1'b0;
            name_next     = NAME_BEGIN;
            vcount_next   = '0;
            vtrim_next    = '0;
            answered_next = 1'b0;
        end else if (accept && !answered_reg) begin
            case (phase_reg)
                PH_LINE_START: begin
                    if (is_line_end(c) || is_blank(c)) begin
                        phase_next = PH_LINE_START;
                    end else if (c inside {CH_SEMI, CH_HASH}) begin
                        phase_next = PH_SKIP;
                    end else if (c == CH_LBRACK) begin
                        name_next  = NAME_BEGIN;
                        phase_next = PH_HDR_LEAD;
                    end else if (in_sec_reg) begin
                        name_next = NAME_BEGIN;
                        if (c == CH_EQUAL) begin
                            if (name_matches(NAME_BEGIN, key_length_reg)) begin
                                vcount_next = '0;
                                vtrim_next  = '0;
                                phase_next  = PH_VAL_LEAD;
                            end else begin
                                phase_next = PH_SKIP;
                            end
                        end else begin
                            name_next  = name_feed(NAME_BEGIN, c, key_name_reg);
                            phase_next = PH_KEY_NAME;
                        end
                    end else begin
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP: begin
                    if (is_line_end(c)) begin
                        phase_next = PH_LINE_START;
                    end
                end
                PH_HDR_LEAD, PH_HDR_NAME: begin
                    if (c == CH_RBRACK || is_line_end(c)) begin
                        in_sec_next = name_matches(name_reg, section_length_reg);
                        phase_next  = is_line_end(c) ? PH_LINE_START : PH_SKIP;
                    end else if (phase_reg == PH_HDR_NAME || !is_blank(c)) begin
                        name_next  = name_feed(name_reg, c, section_name_reg);
                        phase_next = PH_HDR_NAME;
                    end
                end
                PH_KEY_NAME: begin
                    if (is_line_end(c)) begin
                        phase_next = PH_LINE_START;
                    end else if (c == CH_EQUAL) begin
                        if (name_matches(name_reg, key_length_reg)) begin
                            vcount_next = '0;
                            vtrim_next  = '0;
                            phase_next  = PH_VAL_LEAD;
                        end else begin
                            phase_next = PH_SKIP;
                        end
                    end else begin
                        name_next = name_feed(name_reg, c, key_name_reg);
                    end
                end
                default: begin
                    // Value line: capture bytes, answer at line end
                    if (is_line_end(c)) begin
                        push                = 1'b1;
                        answered_next       = 1'b1;
                        busy_next[bank_reg] = 1'b1;
                        bank_next           = !bank_reg;
                    end else if (phase_reg != PH_VAL_DONE) begin
                        if (c inside {CH_SEMI, CH_HASH}) begin
                            phase_next = PH_VAL_DONE;
                        end else if (phase_reg == PH_VAL_BODY || !is_blank(c)) begin
                            if (vcount_reg < VCNT_W'(VALUE_MAX - 1)) begin
                                wr.en       = 1'b1;
                                vcount_next = vcount_reg + 1'b1;
                            end
                            if (!is_blank(c)) begin
                                vtrim_next = vcount_next;
                            end
                            phase_next = PH_VAL_BODY;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_LINE_START;
            in_sec_reg   <= 1'b0;
            name_reg     <= NAME_BEGIN;
            vcount_reg   <= '0;
            vtrim_reg    <= '0;
            answered_reg <= 1'b0;
            bank_reg     <= 1'b0;
            busy_reg     <= '0;
        end else begin
            phase_reg    <= phase_next;
            in_sec_reg   <= in_sec_next;
            name_reg     <= name_next;
            vcount_reg   <= vcount_next;
            vtrim_reg    <= vtrim_next;
            answered_reg <= answered_next;
            bank_reg     <= bank_next;
            busy_reg     <= busy_next;
        end
    end

endmodule

@@ rtl/ikl_back.sv @@
// Output sequencer: two-bank value buffer, read stage and result register.
// Depends on ikl_pkg; takes commands from ikl_cmd_fifo and writes from ikl_front.
module ikl_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  ikl_pkg::wr_t  wr,
    input  logic          cmd_valid,
    input  ikl_pkg::cmd_t cmd,
    output logic          pop,
    output ikl_pkg::rel_t release_bank,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [7:0]    m_value_byte,
    output logic          m_byte_valid,
    output logic          m_key_found,
    output logic          m_last_of_answer
);
    import ikl_pkg::*;

    logic [7:0] buf_mem [2 * VALUE_MAX];
    logic [7:0] rd_data_reg;

    logic [VCNT_W-1:0] k_reg, k_next;
    logic              st1_valid_reg, st1_valid_next;
    logic              st1_byte_reg, st1_byte_next;
    logic              st1_found_reg, st1_found_next;
    logic              st1_last_reg, st1_last_next;

    logic       m_valid_reg;
    logic [7:0] m_value_byte_reg;
    logic       m_byte_valid_reg;
    logic       m_key_found_reg;
    logic       m_last_reg;

    logic              advance;
    logic [ADDR_W-1:0] rd_addr;

    assign advance = !m_valid_reg || m_ready;
    assign rd_addr = buf_addr(cmd.bank, k_reg);

    // Issue the next result of the head command
    always_comb begin
        k_next         = k_reg;
        pop            = 1'b0;
        st1_valid_next = st1_valid_reg;
        st1_byte_next  = st1_byte_reg;
        st1_found_next = st1_found_reg;
        st1_last_next  = st1_last_reg;
        if (advance) begin
            st1_valid_next = cmd_valid;
            st1_byte_next  = 1'b0;
            st1_found_next = cmd.found;
            st1_last_next  = 1'b1;
            if (cmd_valid) begin
                if (cmd.found && (k_reg < cmd.count)) begin
                    st1_byte_next = 1'b1;
                    st1_last_next = 1'b0;
                    k_next        = k_reg + 1'b1;
                end else begin
                    pop    = 1'b1;
                    k_next = '0;
                end
            end
        end
    end

    assign release_bank.en   = pop && cmd.found;
    assign release_bank.bank = cmd.bank;

    // Value buffer: one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            buf_mem[wr.addr] <= wr.data;
        end
        if (advance) begin
            rd_data_reg <= buf_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg         <= '0;
            st1_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            k_reg         <= k_next;
            st1_valid_reg <= st1_valid_next;
            if (advance) begin
                m_valid_reg <= st1_valid_reg;
            end
        end
    end

    // Payload of read stage and result register
    always_ff @(posedge aclk) begin
        st1_byte_reg  <= st1_byte_next;
        st1_found_reg <= st1_found_next;
        st1_last_reg  <= st1_last_next;
        if (advance) begin
            m_value_byte_reg <= st1_byte_reg ? rd_data_reg : 8'h00;
            m_byte_valid_reg <= st1_byte_reg;
            m_key_found_reg  <= st1_found_reg;
            m_last_reg       <= st1_last_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_value_byte     = m_value_byte_reg;
    assign m_byte_valid     = m_byte_valid_reg;
    assign m_key_found      = m_key_found_reg;
    assign m_last_of_answer = m_last_reg;

endmodule

@@ rtl/ikl_checker.sv @@
// Port-level checks of the INI lookup block and their bind to the top level.
// Depends only on the ports of ini_section_key_lookup.
module ikl_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_value_byte,
    input logic       m_byte_valid,
    input logic       m_key_found,
    input logic       m_last_of_answer
);

    // Hold a stalled result unchanged
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_value_byte) &&
        $stable(m_byte_valid) && $stable(m_key_found) && $stable(m_last_of_answer))
        else $error("stalled result changed");

    // Value results are never closing, closing results carry no byte
    a_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_byte_valid != m_last_of_answer) &&
        (m_byte_valid || m_value_byte == 8'h00))
        else $error("bad closing result");

    // A value byte belongs to a found answer, and so does what follows it
    a_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_byte_valid |-> m_key_found ##1 (!m_valid || m_key_found))
        else $error("value byte outside found answer");

    // Drop results during reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind ini_section_key_lookup ikl_checker u_ikl_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_value_byte    (m_value_byte),
    .m_byte_valid    (m_byte_valid),
    .m_key_found     (m_key_found),
    .m_last_of_answer(m_last_of_answer)
);
